// File: rtl/core/prq_pkg.sv
// package for the priority ready queue scheduler
// types, sizes and opcodes for prq_lists and the top level; no dependencies
package prq_pkg;
  localparam int Levels  = 32;
  localparam int Threads = 64;
  localparam int LvlW    = $clog2(Levels);
  localparam int TidW    = $clog2(Threads);
  localparam logic [14:0] LockMax = 15'h7fff;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_REMOVE = 3'd1,
    FN_SCHED  = 3'd2,
    FN_ENTER  = 3'd3,
    FN_EXIT   = 3'd4,
    FN_START  = 3'd5
  } func_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [14:0]      lock_level;
    logic [31:0]      ready_bitmap;
    logic             ready_empty;
    logic             clear_yield;
    logic             switch_in_interrupt;
    logic [LvlW-1:0]  run_priority;
    logic [TidW-1:0]  new_thread;
    logic [TidW-1:0]  old_thread;
    logic             switched;
  } result_t;

  // request to the list engine
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic            at_tail;
    logic [TidW-1:0] tid;
    logic [LvlW-1:0] lvl;
  } list_req_t;
endpackage

// File: rtl/core/prq_ram.sv
// generic single-write, registered-read ram
// no dependencies
module prq_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/prq_lists.sv
// per-level doubly linked thread lists and ready bitmap
// uses prq_pkg and prq_ram; each link table has one write port and one registered read port
module prq_lists (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  prq_pkg::list_req_t       req,
  output logic                     done,
  output logic [31:0]              ready_bits,
  output logic [prq_pkg::TidW-1:0] best_head,
  output logic [prq_pkg::LvlW-1:0] best_lvl
);
  import prq_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_RD   = 5'b00010,
    L_RD2  = 5'b00100,
    L_WR   = 5'b01000,
    L_DONE = 5'b10000
  } lst_t;
  lst_t st;

  logic [Threads-1:0] queued;
  logic [TidW-1:0] head [Levels];
  logic [TidW-1:0] tail [Levels];
  list_req_t r;
  logic [LvlW-1:0] lvl;
  logic [TidW-1:0] nx, pv;

  logic            n_we, p_we, q_we;
  logic [TidW-1:0] n_wa, n_wd, p_wa, p_wd, n_q, p_q;
  logic [LvlW-1:0] q_q;

  prq_ram #(.Width(TidW), .Depth(Threads)) u_next (
    .clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(r.tid), .rdata(n_q));
  prq_ram #(.Width(TidW), .Depth(Threads)) u_prev (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(r.tid), .rdata(p_q));
  // level each queued thread was linked at
  prq_ram #(.Width(LvlW), .Depth(Threads)) u_qlvl (
    .clk, .we(q_we), .waddr(r.tid), .wdata(lvl), .raddr(r.tid), .rdata(q_q));

  assign q_we = (st == L_WR) && r.ins;

  // priority encode of the bitmap
  always_comb begin
    best_lvl = LvlW'(Levels - 1);
    for (int i = Levels - 1; i >= 0; i--)
      if (ready_bits[i]) best_lvl = LvlW'(i);
    best_head = head[best_lvl];
  end

  logic hd, tl, bit_set;
  always_comb begin
    hd = head[lvl] == r.tid;
    tl = tail[lvl] == r.tid;
    bit_set = ready_bits[lvl];
    n_we = 1'b0; p_we = 1'b0;
    n_wa = '0; n_wd = '0; p_wa = '0; p_wd = '0;
    if (st == L_WR && r.ins && bit_set) begin
      if (r.at_tail) begin
        n_we = 1'b1; n_wa = tail[lvl]; n_wd = r.tid;
        p_we = 1'b1; p_wa = r.tid;     p_wd = tail[lvl];
      end else begin
        p_we = 1'b1; p_wa = head[lvl]; p_wd = r.tid;
        n_we = 1'b1; n_wa = r.tid;     n_wd = head[lvl];
      end
    end else if (st == L_WR && r.rem && !hd && !tl) begin
      n_we = 1'b1; n_wa = pv; n_wd = nx;
      p_we = 1'b1; p_wa = nx; p_wd = pv;
    end
  end

  assign done = st == L_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= L_IDLE; queued <= '0; ready_bits <= '0;
    end else begin
      case (st)
        L_IDLE: if (start) begin
          r <= req; st <= L_RD;
        end
        L_RD: st <= L_RD2;
        L_RD2: begin
          lvl <= r.ins ? r.lvl : q_q;
          nx <= n_q; pv <= p_q;
          if ((r.ins && queued[r.tid]) || (r.rem && !queued[r.tid])
              || (!r.ins && !r.rem)) st <= L_DONE;
          else st <= L_WR;
        end
        L_WR: begin
          if (r.ins) begin
            if (!bit_set) begin
              head[lvl] <= r.tid; tail[lvl] <= r.tid;
              ready_bits[lvl] <= 1'b1;
            end else if (r.at_tail) tail[lvl] <= r.tid;
            else head[lvl] <= r.tid;
            queued[r.tid] <= 1'b1;
          end else begin
            if (hd && tl) ready_bits[lvl] <= 1'b0;
            else if (hd) head[lvl] <= nx;
            else if (tl) tail[lvl] <= pv;
            queued[r.tid] <= 1'b0;
          end
          st <= L_DONE;
        end
        L_DONE: st <= L_IDLE;
        default: st <= L_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/priority_ready_queue_scheduler.sv
// top level of the priority ready queue scheduler
// uses prq_pkg and prq_lists
//
// usage:
//  - s_axis carries one request per transfer: func, thread_id,
//    priority_req, yield_flag, current_running, in_interrupt
//  - m_axis carries one result per request
//  - a request runs through a sequencer that calls the shared list engine
//    once for a remove, at most once for an insert, and up to twice for a
//    schedule (requeue of the current thread, then unlink of the new head)
//  - each list call steps through address, read, latch, write and done;
//    the result is registered in S_OUT and offered in S_WAIT; the next
//    request can be taken in the cycle after the result transfer
//  - one request at a time: s_axis_tready is low from acceptance until
//    the result register is free again
//  - reset clears the bitmap, queued flags, running thread and lock depth;
//    link tables keep stale data, which is never read for empty levels
//  - when the receiver stalls, the result holds in m_axis_tdata and no new
//    request is taken
module priority_ready_queue_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[2:0], thread_id[8:3], priority_req[13:9], yield_flag[14],
  // current_running[15], in_interrupt[16], zero fill [23:17]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // switched[0], old_thread[6:1], new_thread[12:7], run_priority[17:13],
  // switch_in_interrupt[18], clear_yield[19], ready_empty[20],
  // ready_bitmap[52:21], lock_level[67:53], zero fill [71:68]
  output logic [71:0] m_axis_tdata
);
  import prq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_LIST1 = 6'b000100,
    S_LIST2 = 6'b001000,
    S_OUT   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;
  state_t st;

  logic [2:0]      func;
  logic [TidW-1:0] tid;
  logic [LvlW-1:0] prio;
  logic            yld, cur_run, intr;
  logic [TidW-1:0] run_tid;
  logic [LvlW-1:0] run_lvl;
  logic            run_valid;
  logic [14:0]     lock;
  result_t         res;
  logic            need_req;  // requeue pending before unlink
  logic [TidW-1:0] pick;

  logic            l_start, l_done;
  list_req_t       l_req;
  logic [31:0]     rbits;
  logic [TidW-1:0] best_head;
  logic [LvlW-1:0] best_lvl;

  prq_lists u_lists (
    .clk, .rst, .start(l_start), .req(l_req), .done(l_done),
    .ready_bits(rbits), .best_head, .best_lvl);

  assign s_axis_tready = st == S_IDLE;
  assign m_axis_tvalid = st == S_WAIT;
  assign m_axis_tdata  = {4'b0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; run_tid <= '0; run_lvl <= '0; run_valid <= 1'b0;
      lock <= '0; l_start <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          l_start <= 1'b0;
          if (s_axis_tvalid) begin
            func <= s_axis_tdata[2:0];
            tid  <= s_axis_tdata[8:3];
            prio <= s_axis_tdata[13:9];
            yld  <= s_axis_tdata[14];
            cur_run <= s_axis_tdata[15];
            intr <= s_axis_tdata[16];
            st <= S_DEC;
          end
        end
        S_DEC: begin
          result_t     rn;
          logic [14:0] nl;
          state_t      sn;
          logic        go, rq;
          list_req_t   lr;
          rn = '0; nl = lock; sn = S_OUT; go = 1'b0; rq = 1'b0; lr = l_req;
          case (func)
            FN_INSERT: if (!(run_valid && tid == run_tid)) begin
              lr = '{ins: 1'b1, rem: 1'b0, at_tail: yld, tid: tid, lvl: prio};
              go = 1'b1; sn = S_LIST2;
            end
            FN_REMOVE: begin
              lr = '{ins: 1'b0, rem: 1'b1, at_tail: 1'b0, tid: tid, lvl: '0};
              go = 1'b1; sn = S_LIST2;
            end
            FN_ENTER: if (lock != LockMax) nl = lock + 15'd1;
            FN_SCHED, FN_EXIT, FN_START: begin
              if (func == FN_EXIT && lock != '0) nl = lock - 15'd1;
              if (func == FN_START || (run_valid && nl == '0)) begin
                if (rbits == '0) rn.ready_empty = 1'b1;
                else begin
                  rn.clear_yield = cur_run && func != FN_START;
                  if (func == FN_START || !cur_run || prio > best_lvl
                      || (prio == best_lvl && yld)) begin
                    rn.switched = 1'b1;
                    rn.old_thread = run_tid;
                    rn.new_thread = best_head;
                    rn.run_priority = best_lvl;
                    rn.switch_in_interrupt = intr && func != FN_START;
                    if (func != FN_START && cur_run) begin
                      lr = '{ins: 1'b1, rem: 1'b0, at_tail: yld,
                             tid: run_tid, lvl: prio};
                      rq = 1'b1;
                    end else
                      lr = '{ins: 1'b0, rem: 1'b1, at_tail: 1'b0,
                             tid: best_head, lvl: '0};
                    go = 1'b1;
                    sn = S_LIST1;
                  end
                end
              end
            end
            default: ;
          endcase
          res <= rn;
          lock <= nl;
          st <= sn;
          l_start <= go;
          need_req <= rq;
          l_req <= lr;
          if (rn.switched) begin
            pick <= best_head;
            run_tid <= best_head; run_lvl <= best_lvl;
            run_valid <= 1'b1;
          end
        end
        S_LIST1: begin
          l_start <= l_done && need_req;
          if (l_done) begin
            if (need_req) begin
              need_req <= 1'b0;
              l_req <= '{ins: 1'b0, rem: 1'b1, at_tail: 1'b0, tid: pick, lvl: '0};
            end else st <= S_OUT;
          end
        end
        S_LIST2: begin
          l_start <= 1'b0;
          if (l_done) st <= S_OUT;
        end
        S_OUT: begin
          l_start <= 1'b0;
          if (!res.switched) begin
            res.old_thread <= run_tid; res.new_thread <= run_tid;
            res.run_priority <= run_lvl;
          end
          res.ready_bitmap <= rbits;
          res.lock_level <= lock;
          st <= S_WAIT;
        end
        S_WAIT: begin
          l_start <= 1'b0;
          if (m_axis_tready) st <= S_IDLE;
        end
        default: begin
          l_start <= 1'b0;
          st <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// File: rtl/core/prq_checker.sv
// port-level checks for the priority ready queue scheduler
// binds to priority_ready_queue_scheduler
module prq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("took second request while busy");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready))
    else $error("ready while result pending");
  a_noswitch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == m_axis_tdata[12:7]
      && !m_axis_tdata[18])
    else $error("no-switch result inconsistent");
endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata);
